// ===== src/eiph_pkg.sv =====
package eiph_pkg;

    typedef enum logic [2:0] {
        LAYER_ETH,
        LAYER_IP,
        LAYER_ARP,
        LAYER_ICMP,
        LAYER_TCP,
        LAYER_UDP,
        LAYER_PAYLOAD
    } layer_t;

    localparam logic [5:0] CODE_PAYLOAD = 6'd37;
    localparam logic [5:0] CODE_END     = 6'd38;
    localparam logic [5:0] CODE_SHORT   = 6'd39;

    localparam int unsigned MIN_FRAME = 14;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [5:0] HDR_MIN_BYTES = 6'd20;

    typedef struct packed {
        logic [5:0]  code;
        logic [47:0] value;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       r0;
        rec_t       r1;
    } res_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } fend_t;

    function automatic logic [5:0] layer_fixed(input layer_t lay);
        logic [5:0] len;
        unique case (lay)
            LAYER_ETH:  len = 6'd14;
            LAYER_IP:   len = 6'd20;
            LAYER_ARP:  len = 6'd28;
            LAYER_ICMP: len = 6'd4;
            LAYER_TCP:  len = 6'd20;
            LAYER_UDP:  len = 6'd8;
            default:    len = 6'd0;
        endcase
        return len;
    endfunction

    function automatic logic [5:0] clamp_len(input logic [3:0] nibble);
        return (nibble < 4'd5) ? HDR_MIN_BYTES : {nibble, 2'b00};
    endfunction

    // n is the header byte count including the current byte
    function automatic fend_t field_end(input layer_t lay, input logic [5:0] n);
        fend_t f;
        f = '0;
        unique case (lay)
            LAYER_ETH: begin
                case (n)
                    6'd6:    f = '{1'b1, 6'd0};
                    6'd12:   f = '{1'b1, 6'd1};
                    6'd14:   f = '{1'b1, 6'd2};
                    default: f = '0;
                endcase
            end
            LAYER_IP: begin
                case (n)
                    6'd1:    f = '{1'b1, 6'd3};
                    6'd2:    f = '{1'b1, 6'd4};
                    6'd4:    f = '{1'b1, 6'd5};
                    6'd6:    f = '{1'b1, 6'd6};
                    6'd8:    f = '{1'b1, 6'd7};
                    6'd9:    f = '{1'b1, 6'd8};
                    6'd10:   f = '{1'b1, 6'd9};
                    6'd12:   f = '{1'b1, 6'd10};
                    6'd16:   f = '{1'b1, 6'd11};
                    6'd20:   f = '{1'b1, 6'd12};
                    default: f = '0;
                endcase
            end
            LAYER_ARP: begin
                case (n)
                    6'd2:    f = '{1'b1, 6'd13};
                    6'd4:    f = '{1'b1, 6'd14};
                    6'd5:    f = '{1'b1, 6'd15};
                    6'd6:    f = '{1'b1, 6'd16};
                    6'd8:    f = '{1'b1, 6'd17};
                    6'd14:   f = '{1'b1, 6'd18};
                    6'd18:   f = '{1'b1, 6'd19};
                    6'd24:   f = '{1'b1, 6'd20};
                    6'd28:   f = '{1'b1, 6'd21};
                    default: f = '0;
                endcase
            end
            LAYER_ICMP: begin
                case (n)
                    6'd1:    f = '{1'b1, 6'd22};
                    6'd2:    f = '{1'b1, 6'd23};
                    6'd4:    f = '{1'b1, 6'd24};
                    default: f = '0;
                endcase
            end
            LAYER_TCP: begin
                case (n)
                    6'd2:    f = '{1'b1, 6'd25};
                    6'd4:    f = '{1'b1, 6'd26};
                    6'd8:    f = '{1'b1, 6'd27};
                    6'd12:   f = '{1'b1, 6'd28};
                    6'd14:   f = '{1'b1, 6'd29};
                    6'd16:   f = '{1'b1, 6'd30};
                    6'd18:   f = '{1'b1, 6'd31};
                    6'd20:   f = '{1'b1, 6'd32};
                    default: f = '0;
                endcase
            end
            LAYER_UDP: begin
                case (n)
                    6'd2:    f = '{1'b1, 6'd33};
                    6'd4:    f = '{1'b1, 6'd34};
                    6'd6:    f = '{1'b1, 6'd35};
                    6'd8:    f = '{1'b1, 6'd36};
                    default: f = '0;
                endcase
            end
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== src/eiph_parse.sv =====
module eiph_parse #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            fire,
    input  logic [7:0]      data_byte,
    input  logic            frame_last,
    output eiph_pkg::res_t  res
);
    import eiph_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES - 1);

    logic [CW-1:0] cnt_reg,   cnt_next;
    layer_t        layer_reg, layer_next;
    logic [5:0]    off_reg,   off_next;
    logic [47:0]   acc_reg,   acc_next;
    logic [5:0]    ip_hdr_reg,  ip_hdr_next;
    logic [5:0]    tcp_hdr_reg, tcp_hdr_next;
    logic [7:0]    proto_reg,   proto_next;

    logic [CW-1:0] cnt_inc;
    logic [47:0]   acc_sh;
    logic [5:0]    off_inc;
    logic [5:0]    hdr_len;
    logic [15:0]   eth_type;
    logic          in_hdr;
    logic          acc_en;
    logic          done;
    logic          have_f;
    logic          have_p;
    logic          have_e;
    fend_t         fe;
    layer_t        nxt;
    rec_t          rec_f;
    rec_t          rec_p;
    rec_t          rec_e;

    always_comb begin
        cnt_inc  = (cnt_reg < CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        acc_sh   = {acc_reg[39:0], data_byte};
        off_inc  = off_reg + 6'd1;
        eth_type = {acc_reg[7:0], data_byte};
        in_hdr   = (layer_reg != LAYER_PAYLOAD);
        acc_en   = in_hdr && (off_reg < layer_fixed(layer_reg));
        fe       = field_end(layer_reg, off_inc);
        have_f   = acc_en && fe.hit;

        unique case (layer_reg)
            LAYER_IP:  hdr_len = ip_hdr_reg;
            LAYER_TCP: hdr_len = tcp_hdr_reg;
            default:   hdr_len = layer_fixed(layer_reg);
        endcase
        done = in_hdr && (off_inc >= hdr_len);

        nxt = LAYER_PAYLOAD;
        if (layer_reg == LAYER_ETH) begin
            if (eth_type == ETYPE_IPV4) nxt = LAYER_IP;
            else if (eth_type == ETYPE_ARP) nxt = LAYER_ARP;
        end else if (layer_reg == LAYER_IP) begin
            if (proto_reg == PROTO_ICMP) nxt = LAYER_ICMP;
            else if (proto_reg == PROTO_TCP) nxt = LAYER_TCP;
            else if (proto_reg == PROTO_UDP) nxt = LAYER_UDP;
        end

        have_p = done && (nxt == LAYER_PAYLOAD) && !frame_last;
        have_e = frame_last;

        rec_f = '{fe.code, acc_sh, 1'b0};
        rec_p = '{CODE_PAYLOAD, 48'(cnt_inc), 1'b0};
        rec_e = '{(cnt_inc < CW'(MIN_FRAME)) ? CODE_SHORT : CODE_END,
                  48'(cnt_inc), 1'b0};

        res.count = 2'(have_f) + 2'(have_p) + 2'(have_e);
        res.r0    = have_f ? rec_f : (have_p ? rec_p : rec_e);
        res.r1    = have_p ? rec_p : rec_e;
        res.r0.last = (res.count == 2'd1);
        res.r1.last = 1'b1;
    end

    always_comb begin
        cnt_next     = cnt_reg;
        layer_next   = layer_reg;
        off_next     = off_reg;
        acc_next     = acc_reg;
        ip_hdr_next  = ip_hdr_reg;
        tcp_hdr_next = tcp_hdr_reg;
        proto_next   = proto_reg;
        if (fire) begin
            cnt_next = cnt_inc;
            if (acc_en) begin
                acc_next = have_f ? '0 : acc_sh;
                if (layer_reg == LAYER_IP && off_reg == 6'd0)
                    ip_hdr_next = clamp_len(data_byte[3:0]);
                if (layer_reg == LAYER_IP && off_reg == 6'd9)
                    proto_next = data_byte;
                if (layer_reg == LAYER_TCP && off_reg == 6'd12)
                    tcp_hdr_next = clamp_len(data_byte[7:4]);
            end
            if (done) begin
                layer_next = nxt;
                off_next   = '0;
                acc_next   = '0;
            end else if (in_hdr) begin
                off_next = off_inc;
            end
            if (frame_last) begin
                cnt_next     = '0;
                layer_next   = LAYER_ETH;
                off_next     = '0;
                acc_next     = '0;
                ip_hdr_next  = HDR_MIN_BYTES;
                tcp_hdr_next = HDR_MIN_BYTES;
                proto_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            layer_reg   <= LAYER_ETH;
            off_reg     <= '0;
            acc_reg     <= '0;
            ip_hdr_reg  <= HDR_MIN_BYTES;
            tcp_hdr_reg <= HDR_MIN_BYTES;
            proto_reg   <= '0;
        end else begin
            cnt_reg     <= cnt_next;
            layer_reg   <= layer_next;
            off_reg     <= off_next;
            acc_reg     <= acc_next;
            ip_hdr_reg  <= ip_hdr_next;
            tcp_hdr_reg <= tcp_hdr_next;
            proto_reg   <= proto_next;
        end
    end

endmodule

// ===== src/ethernet_ipv4_header_parser.sv =====
// Accepted bytes pass the input register; their records are registered into
// the two-entry result queue. Throughput: one byte per cycle while m_ready
// is high; a byte with two records holds the input while the queue drains.
// Reset (aresetn low, synchronous): parser returns to the Ethernet layer with
// zero byte count, input register and result queue empty.
module ethernet_ipv4_header_parser #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_field_code,
    output logic [47:0] m_field_value,
    output logic        m_run_last
);
    import eiph_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg,   byte_next;
    logic       last_reg,   last_next;
    logic [1:0] cnt_reg,    cnt_next;
    rec_t       q0_reg,     q0_next;
    rec_t       q1_reg,     q1_next;

    logic room;
    logic proc;
    logic pop;
    res_t res;

    eiph_parse #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (proc),
        .data_byte  (byte_reg),
        .frame_last (last_reg),
        .res        (res)
    );

    always_comb begin
        pop     = (cnt_reg != 2'd0) && m_ready;
        room    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
        proc    = in_vld_reg && room;
        s_ready = !in_vld_reg || proc;

        in_vld_next = in_vld_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
            byte_next   = s_data_byte;
            last_next   = s_frame_last;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end

        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        if (proc) begin
            cnt_next = res.count;
            q0_next  = res.r0;
            q1_next  = res.r1;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            q0_next  = q1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
    end

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_field_code  = q0_reg.code;
    assign m_field_value = q0_reg.value;
    assign m_run_last    = q0_reg.last;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> (!q0_reg.last && q1_reg.last))
        else $error("run_last misplaced in a record pair");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && res.count == 2'd2) |=> (cnt_reg == 2'd2))
        else $error("record pair not queued");

    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !room) |=> in_vld_reg)
        else $error("input item dropped while queue full");

endmodule
